/* rtl/hts_pkg.sv */
// Shared types and constants for the heap timer scheduler.
package hts_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_KILL  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_SET_OK    = 2'd0;
	localparam logic [1:0] KIND_REJ_COUNT = 2'd1;
	localparam logic [1:0] KIND_REJ_FULL  = 2'd2;
	localparam logic [1:0] KIND_FIRED     = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_RUNNING = 2'd0;
	localparam logic [1:0] REG_MIN_GAP = 2'd1;
	localparam logic [1:0] REG_SLACK   = 2'd2;

	localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;
	localparam int MAX_RESULTS = 64;
	localparam logic [31:0] MIN_GAP_RESET = 32'd100;
	localparam logic [15:0] SLACK_RESET = 16'd5;

	// One classified command handed from the front end to the heap engine.
	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] now;
		logic [31:0] gap;
		logic [31:0] cnt;
		logic [31:0] kid;
	} cmd_t;

	// One heap entry.
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] cnt;
		logic [31:0] gap;
		logic [47:0] last;
		logic        killed;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Heap engine states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KILL_RD,
		ST_KILL_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_POP_RD,
		ST_DOWN_RD,
		ST_DOWN_CHK,
		ST_DOWN_CMP,
		ST_UP_RD,
		ST_UP_CHK,
		ST_EMIT
	} state_t;

endpackage

/* rtl/hts_ram.sv */
// Generic single write port, single read port RAM with registered read.
module hts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/hts_front.sv */
// Front end: accepts items and queues classified commands for the heap engine.
module hts_front #(
	parameter int QDEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     opcode,
	input  logic [47:0]    now_ms,
	input  logic [31:0]    gap_ms,
	input  logic [31:0]    run_count,
	input  logic [31:0]    kill_id,
	output logic           cmd_valid,
	input  logic           cmd_take,
	output hts_pkg::cmd_t  cmd
);

	localparam int PW = $clog2(QDEPTH);

	hts_pkg::cmd_t   q_q [QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            push;
	logic            pop;
	hts_pkg::cmd_t   in_cmd;

	assign in_stall  = (cnt_q == (PW+1)'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_q[rp_q];

	// Pack the item into a command.
	always_comb begin
		in_cmd.op  = opcode;
		in_cmd.now = now_ms;
		in_cmd.gap = gap_ms;
		in_cmd.cnt = run_count;
		in_cmd.kid = kill_id;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= in_cmd;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
		end
	end

endmodule

/* rtl/hts_engine.sv */
// Back end: heap engine that executes set, kill, clear and scan commands.
module hts_engine #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_take,
	input  hts_pkg::cmd_t  cmd,
	input  logic           running,
	input  logic [31:0]    min_gap,
	input  logic [15:0]    slack,
	output logic           res_valid,
	input  logic           res_stall,
	output logic [1:0]     res_kind,
	output logic [31:0]    res_id,
	output logic [31:0]    res_rem,
	output logic           res_last,
	output logic [$clog2(CAPACITY+1)-1:0] size_o
);

	localparam int AW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);
	localparam int NW = $clog2(hts_pkg::MAX_RESULTS + 1);

	hts_pkg::state_t st_q, st_d;

	// Working registers.
	hts_pkg::cmd_t   c_q;
	logic [SW-1:0]   size_q;
	logic [31:0]     next_id_q;
	logic [AW-1:0]   i_q;
	hts_pkg::entry_t cur_q;
	hts_pkg::entry_t top_q;
	hts_pkg::entry_t a_q;
	logic [NW-1:0]   n_q;
	logic [48:0]     limit_q;

	// Pending result register.
	logic            pend_q;
	logic [1:0]      p_kind_q;
	logic [31:0]     p_id_q, p_rem_q;
	logic            p_last_q;
	logic            p_hold_q;

	// Sequencer flags that tell an emit step what comes next.
	logic phase_ins_q;   // pending insert after pop or set
	logic phase_scan_q;  // inside a scan
	logic pop_live_q;    // popped entry produces a result

	// RAM interface.
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	hts_pkg::entry_t wdata, rdata;

	hts_ram #(.WIDTH(hts_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	function automatic logic [48:0] dl(hts_pkg::entry_t e);
		return {1'b0, e.last} + {17'd0, e.gap};
	endfunction

	// Output register drives the result channel.
	logic out_v_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_id_q, out_rem_q;
	logic        out_last_q;
	logic        out_free;

	assign out_free  = !out_v_q || !res_stall;
	assign res_valid = out_v_q;
	assign res_kind  = out_kind_q;
	assign res_id    = out_id_q;
	assign res_rem   = out_rem_q;
	assign res_last  = out_last_q;
	assign size_o    = size_q;

	// Datapath helpers.
	logic [AW:0]     c1, c2, size_x;
	logic [48:0]     dl_cur, dl_rd, dl_a;
	logic            set_ok;
	logic [31:0]     nid;
	logic [31:0]     new_cnt;
	logic            pick_right;
	logic            sink;
	logic            scan_end;
	hts_pkg::entry_t ins_e;

	assign dl_cur = dl(cur_q);
	assign dl_rd  = dl(rdata);
	assign dl_a   = dl(a_q);
	assign size_x = (AW+1)'(size_q);
	assign c1     = {1'b0, i_q} + {1'b0, i_q} + 1'b1;
	assign c2     = c1 + 1'b1;
	assign set_ok = (c_q.cnt != '0) && (size_q < SW'(CAPACITY));
	assign nid    = (next_id_q == hts_pkg::FOREVER) ? 32'd1 : next_id_q + 32'd1;
	assign new_cnt = (top_q.cnt == hts_pkg::FOREVER) ? top_q.cnt : top_q.cnt - 32'd1;
	assign pick_right = (c2 < size_x) && (dl_cur > dl_rd);
	assign sink   = dl_a > (pick_right ? dl_rd : dl_cur);
	assign scan_end = (st_q == hts_pkg::ST_SCAN_RD &&
	                   (n_q == NW'(hts_pkg::MAX_RESULTS) || size_q == '0)) ||
	                  (st_q == hts_pkg::ST_SCAN_CHK && !(dl_rd <= limit_q));

	// Entry to insert: a new timer on set, the fired entry on reinsert.
	always_comb begin
		ins_e.id     = phase_scan_q ? top_q.id : nid;
		ins_e.cnt    = phase_scan_q ? new_cnt : c_q.cnt;
		ins_e.gap    = phase_scan_q ? top_q.gap : ((c_q.gap < min_gap) ? min_gap : c_q.gap);
		ins_e.last   = c_q.now;
		ins_e.killed = 1'b0;
	end

	// Emit step decode.
	logic act_rej_cnt, act_rej_full, act_set_ins, act_set_done;
	logic act_reins, act_fire, act_drop, need_pend;
	logic emit_go, ld_rej, ld_done, fire_now, ins_go, set_go, xfer;

	assign act_rej_cnt  = !phase_scan_q && c_q.cnt == '0;
	assign act_rej_full = !phase_scan_q && c_q.cnt != '0 && !phase_ins_q && !set_ok;
	assign act_set_ins  = !phase_scan_q && c_q.cnt != '0 && !phase_ins_q && set_ok;
	assign act_set_done = !phase_scan_q && c_q.cnt != '0 && phase_ins_q;
	assign act_reins    = phase_scan_q && phase_ins_q;
	assign act_fire     = phase_scan_q && !phase_ins_q && pop_live_q;
	assign act_drop     = phase_scan_q && !phase_ins_q && !pop_live_q;
	assign need_pend    = act_rej_cnt || act_rej_full || act_set_ins || act_set_done;

	// A fired result waits in the pending register until the scan shows whether
	// it is the last one; the next fired result pushes it out.
	assign emit_go  = (st_q == hts_pkg::ST_EMIT) &&
	                  (need_pend ? !pend_q :
	                   act_fire ? (!pend_q || (p_hold_q && out_free)) : 1'b1);
	assign ld_rej   = emit_go && (act_rej_cnt || act_rej_full);
	assign ld_done  = emit_go && act_set_done;
	assign fire_now = emit_go && act_fire;
	assign ins_go   = emit_go && (act_set_ins || act_reins);
	assign set_go   = emit_go && act_set_ins;
	assign xfer     = out_free && pend_q && (!p_hold_q || fire_now);

	// Next state and memory control.
	always_comb begin
		st_d     = st_q;
		cmd_take = 1'b0;
		we       = 1'b0;
		waddr    = i_q;
		wdata    = cur_q;
		raddr    = i_q;
		case (st_q)
			hts_pkg::ST_IDLE: begin
				if (cmd_valid && !pend_q) begin
					cmd_take = 1'b1;
					case (cmd.op)
						hts_pkg::OP_SET:   st_d = hts_pkg::ST_EMIT;
						hts_pkg::OP_KILL:  st_d = (cmd.kid != '0 && size_q != '0) ?
						                          hts_pkg::ST_KILL_RD : hts_pkg::ST_IDLE;
						hts_pkg::OP_CLEAR: st_d = hts_pkg::ST_IDLE;
						default:           st_d = (running && size_q != '0) ?
						                          hts_pkg::ST_SCAN_RD : hts_pkg::ST_IDLE;
					endcase
				end
			end
			hts_pkg::ST_KILL_RD: begin
				st_d = hts_pkg::ST_KILL_CHK;
			end
			hts_pkg::ST_KILL_CHK: begin
				if (rdata.id == c_q.kid) begin
					we = 1'b1;
					wdata = rdata;
					wdata.killed = 1'b1;
				end
				st_d = ({1'b0, i_q} + 1'b1 >= size_x) ? hts_pkg::ST_IDLE :
				       hts_pkg::ST_KILL_RD;
			end
			hts_pkg::ST_SCAN_RD: begin
				raddr = '0;
				if (n_q == NW'(hts_pkg::MAX_RESULTS) || size_q == '0) begin
					st_d = hts_pkg::ST_IDLE;
				end else begin
					st_d = hts_pkg::ST_SCAN_CHK;
				end
			end
			hts_pkg::ST_SCAN_CHK: begin
				raddr = AW'(size_q - 1'b1);
				st_d = (dl_rd <= limit_q) ? hts_pkg::ST_POP_RD : hts_pkg::ST_IDLE;
			end
			hts_pkg::ST_POP_RD: begin
				// rdata is the last entry; it moves to the root and sinks.
				raddr = AW'(c1);
				st_d = hts_pkg::ST_DOWN_RD;
			end
			hts_pkg::ST_DOWN_RD: begin
				raddr = AW'(c1);
				if (c1 >= size_x) begin
					we = 1'b1;
					wdata = a_q;
					st_d = hts_pkg::ST_EMIT;
				end else begin
					st_d = hts_pkg::ST_DOWN_CHK;
				end
			end
			hts_pkg::ST_DOWN_CHK: begin
				raddr = AW'(c2);
				st_d = hts_pkg::ST_DOWN_CMP;
			end
			hts_pkg::ST_DOWN_CMP: begin
				// cur_q holds the left child, rdata the right one.
				we = 1'b1;
				if (sink) begin
					wdata = pick_right ? rdata : cur_q;
					st_d = hts_pkg::ST_DOWN_RD;
				end else begin
					wdata = a_q;
					st_d = hts_pkg::ST_EMIT;
				end
			end
			hts_pkg::ST_UP_RD: begin
				raddr = AW'(({1'b0, i_q} - 1'b1) >> 1);
				if (i_q == '0) begin
					we = 1'b1;
					wdata = a_q;
					st_d = hts_pkg::ST_EMIT;
				end else begin
					st_d = hts_pkg::ST_UP_CHK;
				end
			end
			hts_pkg::ST_UP_CHK: begin
				we = 1'b1;
				if (dl_a < dl_rd) begin
					wdata = rdata;
					st_d = hts_pkg::ST_UP_RD;
				end else begin
					wdata = a_q;
					st_d = hts_pkg::ST_EMIT;
				end
			end
			hts_pkg::ST_EMIT: begin
				if (emit_go) begin
					if (act_set_ins || act_reins) begin
						st_d = hts_pkg::ST_UP_RD;
					end else if (act_fire || act_drop) begin
						st_d = hts_pkg::ST_SCAN_RD;
					end else begin
						st_d = hts_pkg::ST_IDLE;
					end
				end
			end
			default: st_d = hts_pkg::ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= hts_pkg::ST_IDLE;
			size_q       <= '0;
			next_id_q    <= '0;
			pend_q       <= 1'b0;
			p_hold_q     <= 1'b0;
			p_last_q     <= 1'b0;
			out_v_q      <= 1'b0;
			phase_ins_q  <= 1'b0;
			phase_scan_q <= 1'b0;
			pop_live_q   <= 1'b0;
			n_q          <= '0;
		end else begin
			st_q <= st_d;
			if (out_free) begin
				out_v_q <= xfer;
			end
			if (ld_rej || ld_done || fire_now) begin
				pend_q <= 1'b1;
			end else if (xfer) begin
				pend_q <= 1'b0;
			end
			if (fire_now) begin
				p_hold_q <= 1'b1;
			end else if (scan_end) begin
				p_hold_q <= 1'b0;
			end
			if (ld_rej || ld_done) begin
				p_last_q <= 1'b1;
			end else if (fire_now) begin
				p_last_q <= 1'b0;
			end else if (scan_end) begin
				p_last_q <= 1'b1;
			end
			if (st_q == hts_pkg::ST_IDLE && cmd_take && cmd.op == hts_pkg::OP_CLEAR) begin
				size_q <= '0;
			end else if (st_q == hts_pkg::ST_POP_RD) begin
				size_q <= size_q - 1'b1;
			end else if (ins_go) begin
				size_q <= size_q + 1'b1;
			end
			if (set_go) begin
				next_id_q <= nid;
			end
			if (st_q == hts_pkg::ST_POP_RD) begin
				phase_ins_q <= !top_q.killed && top_q.cnt > 32'd1;
			end else if (set_go) begin
				phase_ins_q <= 1'b1;
			end else if (ld_done || (emit_go && act_reins)) begin
				phase_ins_q <= 1'b0;
			end
			if (st_q == hts_pkg::ST_POP_RD) begin
				pop_live_q <= !top_q.killed && top_q.cnt != '0;
			end else if (fire_now) begin
				pop_live_q <= 1'b0;
			end
			if (st_q == hts_pkg::ST_IDLE && cmd_take) begin
				phase_scan_q <= (cmd.op == hts_pkg::OP_SCAN);
			end
			if (st_q == hts_pkg::ST_IDLE && cmd_take) begin
				n_q <= '0;
			end else if (fire_now) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (st_q == hts_pkg::ST_IDLE && cmd_take) begin
			c_q     <= cmd;
			limit_q <= {1'b0, cmd.now} + {33'd0, slack};
		end
		case (st_q)
			hts_pkg::ST_IDLE: begin
				if (cmd_take) begin
					i_q <= '0;
				end
			end
			hts_pkg::ST_KILL_CHK: i_q <= i_q + 1'b1;
			hts_pkg::ST_POP_RD: i_q <= '0;
			hts_pkg::ST_DOWN_CMP: begin
				if (sink) begin
					i_q <= pick_right ? AW'(c2) : AW'(c1);
				end
			end
			hts_pkg::ST_UP_CHK: begin
				if (dl_a < dl_rd) begin
					i_q <= AW'(({1'b0, i_q} - 1'b1) >> 1);
				end
			end
			hts_pkg::ST_EMIT: begin
				if (ins_go) begin
					i_q <= AW'(size_q);
				end
			end
			default: ;
		endcase
		if (st_q == hts_pkg::ST_SCAN_CHK) begin
			top_q <= rdata;
		end
		if (st_q == hts_pkg::ST_DOWN_CHK) begin
			cur_q <= rdata;
		end
		if (st_q == hts_pkg::ST_POP_RD) begin
			a_q <= rdata;
		end else if (ins_go) begin
			a_q <= ins_e;
		end
		// Load the pending result fields.
		if (ld_rej) begin
			p_kind_q <= act_rej_cnt ? hts_pkg::KIND_REJ_COUNT : hts_pkg::KIND_REJ_FULL;
			p_id_q   <= '0;
			p_rem_q  <= '0;
		end else if (set_go) begin
			p_kind_q <= hts_pkg::KIND_SET_OK;
			p_id_q   <= nid;
			p_rem_q  <= c_q.cnt;
		end else if (fire_now) begin
			p_kind_q <= hts_pkg::KIND_FIRED;
			p_id_q   <= top_q.id;
			p_rem_q  <= (top_q.cnt > 32'd1) ? new_cnt : 32'd0;
		end
		// Move a pending result into the output register.
		if (xfer) begin
			out_kind_q <= p_kind_q;
			out_id_q   <= p_id_q;
			out_rem_q  <= p_rem_q;
			out_last_q <= p_last_q;
		end
	end

endmodule

/* rtl/heap_timer_scheduler.sv */
// Top level of the heap timer scheduler.
//
//  Channel | Signals                                  | Direction
//  input   | in_valid, in_stall, opcode..kill_id      | item in
//  output  | out_valid, out_stall, kind..last_in_run | result out
//  config  | cfg_we, cfg_index, cfg_data              | register write
//
// A set sifts its entry up, a kill checks each stored entry in turn, and a scan
// sifts down each popped entry; every step reads the single-read-port entry RAM.
// Reset clears the control state; the entry RAM needs no clearing. A two-entry
// command queue lets input items arrive while the heap engine works or waits on
// out_stall.
module heap_timer_scheduler #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [47:0] now_ms,
	input  logic [31:0] gap_ms,
	input  logic [31:0] run_count,
	input  logic [31:0] kill_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] timer_id,
	output logic [31:0] remaining,
	output logic        last_in_run,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic           running_q;
	logic [31:0]    min_gap_q;
	logic [15:0]    slack_q;
	logic           cmd_valid, cmd_take;
	hts_pkg::cmd_t  cmd;
	logic [$clog2(CAPACITY+1)-1:0] size;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			min_gap_q <= hts_pkg::MIN_GAP_RESET;
			slack_q   <= hts_pkg::SLACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hts_pkg::REG_RUNNING: running_q <= cfg_data[0];
				hts_pkg::REG_MIN_GAP: min_gap_q <= cfg_data;
				hts_pkg::REG_SLACK:   slack_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	hts_front #(.QDEPTH(2)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.now_ms    (now_ms),
		.gap_ms    (gap_ms),
		.run_count (run_count),
		.kill_id   (kill_id),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	hts_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.running   (running_q),
		.min_gap   (min_gap_q),
		.slack     (slack_q),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res_kind  (kind),
		.res_id    (timer_id),
		.res_rem   (remaining),
		.res_last  (last_in_run),
		.size_o    (size)
	);

	// The heap never holds more entries than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		size <= ($clog2(CAPACITY+1))'(CAPACITY))
		else $error("heap size above capacity");

	// A fired result never carries a zero id.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == hts_pkg::KIND_FIRED |-> timer_id != '0)
		else $error("fired result with zero id");

	// An accepted set always carries a nonzero id and is marked last in run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == hts_pkg::KIND_SET_OK |-> timer_id != '0 && last_in_run)
		else $error("bad set result");

endmodule
